FILE: rtl/kmp_first_match_finder_macros.svh
`ifndef KMP_FIRST_MATCH_FINDER_MACROS_SVH
`define KMP_FIRST_MATCH_FINDER_MACROS_SVH

// Same-cycle implication, disabled while the asynchronous reset is low.
`define KMP_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while the asynchronous reset is low.
`define KMP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/kmp_pkg.sv
`timescale 1ns / 1ps

package kmp_pkg;

	// Fixed payload widths of the channels.
	localparam int IN_W  = 32;
	localparam int POS_W = 21;

	// Controller states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_EMIT = 3'b100
	} ctrl_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic accept;  // take the input beat, issue the first table read
		logic step;    // follow one failure link
		logic finish;  // commit the item, produce its result if any
		logic emit;    // move the held result into the output register
	} kmp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic done;       // comparison loop has settled
		logic res_valid;  // the item being finished produces a result
		logic out_free;   // output register can take a result this cycle
	} kmp_sts_t;

endpackage

FILE: rtl/kmp_item_if.sv
`timescale 1ns / 1ps

interface kmp_item_if import kmp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   command;
	logic signed [IN_W-1:0] element_value;
	logic                   last_element;

	modport source (output valid, command, element_value, last_element, input ready);
	modport sink (input valid, command, element_value, last_element, output ready);
endinterface

FILE: rtl/kmp_result_if.sv
`timescale 1ns / 1ps

interface kmp_result_if import kmp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] start_position;

	modport source (output valid, found, start_position, input ready);
	modport sink (input valid, found, start_position, output ready);
endinterface

FILE: rtl/kmp_ctrl.sv
`timescale 1ns / 1ps

module kmp_ctrl import kmp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  kmp_sts_t sts,
	output kmp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!sts.done) begin
					cmd.step = 1'b1;
				end else begin
					cmd.finish = 1'b1;
					// park the result if the output register is still occupied
					if (sts.res_valid && !sts.out_free) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/kmp_dpath.sv
`timescale 1ns / 1ps
`include "kmp_first_match_finder_macros.svh"

module kmp_dpath import kmp_pkg::*; #(
	parameter int              ELEM_WIDTH = 32,
	parameter int              PAT_MAX    = 4096,
	parameter longint unsigned TEXT_MAX   = 1048576
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kmp_cmd_t               cmd,
	output kmp_sts_t               sts,
	input  logic                   command,
	input  logic signed [IN_W-1:0] element_value,
	input  logic                   last_element,
	input  logic                   result_ready,
	output logic                   result_valid,
	output logic                   result_found,
	output logic [POS_W-1:0]       result_start_position
);

	localparam int IDX_W  = $clog2(PAT_MAX);
	localparam int LEN_W  = $clog2(PAT_MAX + 1);
	localparam int TIDX_W = $clog2(TEXT_MAX + 1);
	localparam int SW     = ((TIDX_W > LEN_W) ? TIDX_W : LEN_W) + 1;
	localparam int XW     = (ELEM_WIDTH > IN_W) ? ELEM_WIDTH : IN_W;

	// Pattern and failure tables.
	logic [ELEM_WIDTH-1:0] pat_mem  [PAT_MAX];
	logic [IDX_W-1:0]      fail_mem [PAT_MAX];
	logic [ELEM_WIDTH-1:0] pat_rd_q;
	logic [IDX_W-1:0]      fail_rd_q;

	// Item being worked on.
	logic [ELEM_WIDTH-1:0] v_q;
	logic [IDX_W-1:0]      j_q, i_q;
	logic                  text_q, last_q, skip_q, store_q, active_q;

	// Search state.
	logic [LEN_W-1:0]  pat_len_q;
	logic              pat_complete_q;
	logic [IDX_W-1:0]  border_q, match_len_q;
	logic [TIDX_W-1:0] text_idx_q;
	logic              reported_q;

	// Output register and held result.
	logic             out_valid_q, out_found_q, pend_found_q;
	logic [POS_W-1:0] out_pos_q, pend_pos_q;

	logic [XW-1:0]         elem_x;
	logic [ELEM_WIDTH-1:0] elem;
	logic                  fresh, room, text_on, a_skip, hit, hit_eff, full, out_load;
	logic [LEN_W-1:0]      eff_len, len_m1;
	logic [IDX_W-1:0]      j_start, rd_addr, j_new;
	logic [SW-1:0]         start_w;
	logic                  res_found;
	logic [POS_W-1:0]      res_pos;

	assign elem_x = XW'(element_value);
	assign elem   = elem_x[ELEM_WIDTH-1:0];

	// Accept-cycle decode: a pattern beat after completion starts a new pattern.
	assign fresh   = pat_complete_q;
	assign eff_len = fresh ? '0 : pat_len_q;
	assign room    = eff_len < LEN_W'(PAT_MAX);
	assign text_on = pat_complete_q && (pat_len_q != '0);
	assign j_start = command ? match_len_q : (fresh ? '0 : border_q);
	assign a_skip  = command ? (!text_on || reported_q) : (!room || (eff_len == '0));
	assign rd_addr = cmd.accept ? j_start : fail_rd_q;

	// Loop evaluation.
	assign hit     = pat_rd_q == v_q;
	assign hit_eff = !skip_q && hit;
	assign j_new   = hit_eff ? j_q + IDX_W'(1) : j_q;
	assign len_m1  = pat_len_q - LEN_W'(1);
	assign full    = text_q && active_q && !reported_q && hit_eff && (LEN_W'(j_q) == len_m1);

	assign start_w = (SW'(text_idx_q) >= SW'(pat_len_q)) ?
		SW'(text_idx_q) - SW'(pat_len_q) + SW'(1) : SW'(1);
	assign res_found = full;
	assign res_pos   = full ? POS_W'(start_w) : '0;

	assign sts.done      = skip_q || (j_q == '0) || hit;
	assign sts.res_valid = text_q && active_q && (full || (last_q && !reported_q));
	assign sts.out_free  = !out_valid_q || result_ready;

	assign out_load = (cmd.finish && sts.res_valid && sts.out_free) || cmd.emit;

	always_ff @(posedge clk) begin
		if (cmd.accept && !command && room) begin
			pat_mem[eff_len[IDX_W-1:0]] <= elem;
		end
		if (cmd.finish && !text_q && store_q) begin
			fail_mem[i_q] <= j_new;
		end
		if (cmd.accept || cmd.step) begin
			pat_rd_q  <= pat_mem[rd_addr];
			fail_rd_q <= fail_mem[rd_addr - IDX_W'(1)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q <= elem;
			i_q <= eff_len[IDX_W-1:0];
		end
		if (cmd.finish && sts.res_valid) begin
			pend_found_q <= res_found;
			pend_pos_q   <= res_pos;
		end
		if (out_load) begin
			out_found_q <= cmd.emit ? pend_found_q : res_found;
			out_pos_q   <= cmd.emit ? pend_pos_q : res_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q            <= '0;
			text_q         <= 1'b0;
			last_q         <= 1'b0;
			skip_q         <= 1'b0;
			store_q        <= 1'b0;
			active_q       <= 1'b0;
			pat_len_q      <= '0;
			pat_complete_q <= 1'b0;
			border_q       <= '0;
			match_len_q    <= '0;
			text_idx_q     <= '0;
			reported_q     <= 1'b0;
		end else if (cmd.accept) begin
			j_q      <= j_start;
			text_q   <= command;
			last_q   <= last_element;
			skip_q   <= a_skip;
			store_q  <= room;
			active_q <= text_on;
			if (!command && fresh) begin
				pat_len_q      <= '0;
				pat_complete_q <= 1'b0;
				border_q       <= '0;
				match_len_q    <= '0;
				text_idx_q     <= '0;
				reported_q     <= 1'b0;
			end
			if (command && text_on && (text_idx_q < TIDX_W'(TEXT_MAX))) begin
				text_idx_q <= text_idx_q + TIDX_W'(1);
			end
		end else if (cmd.step) begin
			j_q <= fail_rd_q;
		end else if (cmd.finish) begin
			if (!text_q) begin
				if (store_q) begin
					border_q  <= j_new;
					pat_len_q <= LEN_W'(i_q) + LEN_W'(1);
				end
				if (last_q) begin
					pat_complete_q <= 1'b1;
					match_len_q    <= '0;
					text_idx_q     <= '0;
					reported_q     <= 1'b0;
				end
			end else if (active_q) begin
				if (!reported_q) begin
					if (full) begin
						reported_q  <= 1'b1;
						match_len_q <= '0;
					end else begin
						match_len_q <= j_new;
					end
				end
				if (last_q) begin
					match_len_q <= '0;
					text_idx_q  <= '0;
					reported_q  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid          = out_valid_q;
	assign result_found          = out_found_q;
	assign result_start_position = out_pos_q;

	`KMP_ASSERT_NEXT(a_link_shrinks, clk, arst_n, cmd.step, j_q < $past(j_q), "failure link did not shrink")
	`KMP_ASSERT_SAME(a_match_in_range, clk, arst_n, pat_complete_q, LEN_W'(match_len_q) < pat_len_q, "match length reached pattern length")
	`KMP_ASSERT_SAME(a_border_in_range, clk, arst_n, pat_len_q != '0, LEN_W'(border_q) < pat_len_q, "border not below pattern length")

endmodule

FILE: rtl/kmp_first_match_finder.sv
`timescale 1ns / 1ps

// First-match string search over integer elements (Knuth-Morris-Pratt). Send the
// pattern as beats with command = 0, the final one flagged by last_element; the
// failure table is built as each element arrives. Then send text beats with
// command = 1, last_element on the final one. The first full match gives one
// result beat with found = 1 and the 1-based start position; nothing more comes
// until the text ends. A text that ends without a match gives found = 0 and
// position 0 on its last beat. A pattern beat after a completed pattern starts a
// new pattern; text beats before the pattern is complete are dropped; pattern
// elements beyond PAT_MAX are dropped. Each beat is accepted, then compared and
// committed, with one failure-link fallback step between for each link followed;
// each fallback is one registered read of the pattern and failure tables.
// Fallbacks never outnumber earlier advances. A new beat is taken only when the
// block is idle again. A result that finds the output register still occupied
// is held until the sink takes it. Elements compare on their low ELEM_WIDTH
// bits; the position counter saturates at TEXT_MAX.
module kmp_first_match_finder import kmp_pkg::*; #(
	parameter int              ELEM_WIDTH = 32,
	parameter int              PAT_MAX    = 4096,
	parameter longint unsigned TEXT_MAX   = 1048576
) (
	input  logic         clk,
	input  logic         arst_n,
	kmp_item_if.sink     item,
	kmp_result_if.source result
);

	kmp_cmd_t cmd;
	kmp_sts_t sts;

	// Sequence each beat: accept, walk failure links, commit, hold result.
	kmp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Tables, match state and the output register.
	kmp_dpath #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.PAT_MAX    (PAT_MAX),
		.TEXT_MAX   (TEXT_MAX)
	) u_dpath (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.sts                   (sts),
		.command               (item.command),
		.element_value         (item.element_value),
		.last_element          (item.last_element),
		.result_ready          (result.ready),
		.result_valid          (result.valid),
		.result_found          (result.found),
		.result_start_position (result.start_position)
	);

endmodule

FILE: sim/kmp_first_match_finder_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the first-match string search block.
// A queue of beats is built up front. A negedge driver feeds it to the item
// channel, and a posedge monitor predicts the search on every accepted beat
// and checks every result beat against the oldest outstanding report.
module kmp_first_match_finder_tb;
	import kmp_pkg::*;

	localparam int              PAT_MAX      = 4096;
	localparam longint unsigned TEXT_MAX     = 1048576;
	localparam bit              CMD_PATTERN  = 1'b0;
	localparam bit              CMD_TEXT     = 1'b1;
	localparam int              RANDOM_BEATS = 400;
	localparam int              MIN_TEXTS    = 12;
	localparam int              BURST_TEXTS  = 40;
	localparam int              HOLD_CYCLES  = 300;
	localparam int              DRAIN_CYCLES = 40;
	localparam int              CALM_ROUNDS  = 2;
	localparam longint          LIMIT_NS     = 8_000_000;

	// Search round variants; any value below KIND_NOISE gives a clean round.
	localparam int              KIND_CLEAN   = 0;
	localparam int              KIND_NOISE   = 7;
	localparam int              KIND_STRAY   = 8;
	localparam int              KIND_CUT     = 9;

	typedef struct {
		bit               command;
		logic [IN_W-1:0]  value;
		bit               last;
	} beat_t;

	typedef struct {
		bit               found;
		logic [POS_W-1:0] start;
	} report_t;

	logic clk;
	logic arst_n;

	kmp_item_if   item_ch ();
	kmp_result_if result_ch ();

	kmp_first_match_finder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Shadow search state, mirroring the block's pattern and text bookkeeping.
	logic [IN_W-1:0] pat_elem [PAT_MAX];
	int unsigned     pat_link [PAT_MAX];
	int unsigned     pat_len        = 0;
	int unsigned     border_len     = 0;
	int unsigned     matched_len    = 0;
	bit              pat_done       = 0;
	bit              first_reported = 0;
	longint unsigned text_pos       = 0;
	report_t         pending_reports [$];

	// Stimulus and handshake bookkeeping.
	beat_t           beats_to_send [$];
	logic [IN_W-1:0] run_buf [$];
	logic [IN_W-1:0] pat_copy [$];
	logic [IN_W-1:0] alphabet [$];
	int unsigned     total_beats   = 0;
	int unsigned     burst_at      = 0;
	int unsigned     calm_from     = 0;
	int unsigned     items_in      = 0;
	int unsigned     items_offered = 0;
	int unsigned     send_gap      = 0;
	int unsigned     sink_gap      = 0;
	bit              sink_hold     = 0;
	int              mismatches    = 0;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	task automatic clear_text_state();
		matched_len    = 0;
		text_pos       = 0;
		first_reported = 0;
	endtask

	// Advance the shadow search by one accepted beat; queue a report if the
	// beat completes the first match, or ends a text that never matched.
	task automatic predict_first_match(input beat_t b);
		int unsigned     j;
		longint unsigned start;
		report_t         rep;
		if (b.command == CMD_PATTERN) begin
			// A pattern beat after a completed pattern starts over. Old table
			// entries need no wipe: only entries below pat_len are ever read.
			if (pat_done) begin
				pat_len    = 0;
				pat_done   = 0;
				border_len = 0;
				clear_text_state();
			end
			// Elements past the table depth are dropped, but their last flag
			// still closes the pattern below.
			if (pat_len < PAT_MAX) begin
				j = 0;
				pat_elem[pat_len] = b.value;
				if (pat_len > 0) begin
					j = border_len;
					while (j > 0 && pat_elem[j] != b.value)
						j = pat_link[j-1];
					if (pat_elem[j] == b.value)
						j++;
				end
				pat_link[pat_len] = j;
				border_len = j;
				pat_len++;
			end
			if (b.last) begin
				pat_done = 1;
				clear_text_state();
			end
		end else if (pat_done && pat_len != 0) begin
			// Text beats before the pattern is closed fall through silently.
			if (text_pos < TEXT_MAX)
				text_pos++;
			if (!first_reported) begin
				j = matched_len;
				while (j > 0 && pat_elem[j] != b.value)
					j = pat_link[j-1];
				if (pat_elem[j] == b.value)
					j++;
				if (j >= pat_len) begin
					start = 1;
					if (text_pos + 1 > pat_len)
						start = text_pos + 1 - pat_len;
					rep.found = 1'b1;
					rep.start = start[POS_W-1:0];
					pending_reports.push_back(rep);
					first_reported = 1;
					j = 0;
				end
				matched_len = j;
			end
			if (b.last) begin
				if (!first_reported) begin
					rep.found = 1'b0;
					rep.start = '0;
					pending_reports.push_back(rep);
				end
				clear_text_state();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------

	task automatic add_beat(input bit cmd, input logic [IN_W-1:0] v, input bit last);
		beats_to_send.push_back('{command: cmd, value: v, last: last});
	endtask

	// Flush run_buf as one run of beats, flagging the final one if closing.
	task automatic add_run(input bit cmd, input bit closing);
		foreach (run_buf[k])
			add_beat(cmd, run_buf[k], closing && (k == run_buf.size() - 1));
		run_buf.delete();
	endtask

	function automatic logic [IN_W-1:0] any_symbol();
		return alphabet[$urandom_range(0, alphabet.size() - 1)];
	endfunction

	// One pattern followed by a few texts over a small alphabet, so matches
	// and failure-link fallbacks are common. The kind selects a variant:
	// texts of raw noise, stray text beats inside the pattern load, or the
	// last text cut off by the next pattern; anything else is clean.
	task automatic add_search_round(input int kind, output int texts_closed);
		int unsigned n_sym;
		int unsigned plen;
		int unsigned n_texts;
		int unsigned tlen;
		int unsigned ins_at;
		bit          ins;
		texts_closed = 0;
		alphabet.delete();
		n_sym = $urandom_range(1, 3);
		for (int i = 0; i < n_sym; i++) begin
			if ($urandom_range(0, 3) == 0)
				alphabet.push_back($urandom_range(0, 3));
			else
				alphabet.push_back($urandom());
		end
		plen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
		pat_copy.delete();
		for (int i = 0; i < plen; i++)
			pat_copy.push_back(any_symbol());

		if (kind == KIND_STRAY) begin
			foreach (pat_copy[i]) begin
				add_beat(CMD_PATTERN, pat_copy[i], i == plen - 1);
				if (i < plen - 1 && $urandom_range(0, 2) == 0)
					add_beat(CMD_TEXT, $urandom(), $urandom_range(0, 1));
			end
		end else begin
			run_buf = pat_copy;
			add_run(CMD_PATTERN, 1);
		end

		n_texts = $urandom_range(1, 3);
		for (int t = 0; t < n_texts; t++) begin
			tlen   = $urandom_range(1, 30);
			ins    = $urandom_range(0, 1);
			ins_at = $urandom_range(0, tlen - 1);
			for (int k = 0; k < tlen; k++) begin
				if (kind == KIND_NOISE)
					run_buf.push_back($urandom());
				else if (ins && k == ins_at)
					foreach (pat_copy[m]) run_buf.push_back(pat_copy[m]);
				else
					run_buf.push_back(any_symbol());
			end
			if (kind == KIND_CUT && t == n_texts - 1) begin
				add_run(CMD_TEXT, 0);
			end else begin
				add_run(CMD_TEXT, 1);
				texts_closed++;
			end
		end
	endtask

	task automatic build_stimulus();
		logic [IN_W-1:0] v_min;
		logic [IN_W-1:0] v_max;
		logic [IN_W-1:0] v_ones;
		logic [IN_W-1:0] fill;
		int unsigned     rand_start;
		int              texts_done;
		int              closed;
		v_min  = 32'h8000_0000;
		v_max  = 32'h7FFF_FFFF;
		v_ones = 32'hFFFF_FFFF;

		// Text before any pattern: dropped.
		add_beat(CMD_TEXT, v_max, 1);
		// Pattern min/max/min with a stray text beat mid-load (also dropped).
		add_beat(CMD_PATTERN, v_min, 0);
		add_beat(CMD_TEXT, v_ones, 1);
		add_beat(CMD_PATTERN, v_max, 0);
		add_beat(CMD_PATTERN, v_min, 1);
		// Match at position 4 after a partial false start; the tail stays silent.
		add_beat(CMD_TEXT, v_min, 0);
		add_beat(CMD_TEXT, v_max, 0);
		add_beat(CMD_TEXT, v_max, 0);
		add_beat(CMD_TEXT, v_min, 0);
		add_beat(CMD_TEXT, v_max, 0);
		add_beat(CMD_TEXT, v_min, 0);
		add_beat(CMD_TEXT, '0, 0);
		add_beat(CMD_TEXT, v_ones, 1);
		// A text with no match reports not-found on its last beat.
		add_beat(CMD_TEXT, '0, 0);
		add_beat(CMD_TEXT, v_ones, 1);
		// New pattern over a complete one; match and text end on one beat.
		add_beat(CMD_PATTERN, v_ones, 1);
		add_beat(CMD_TEXT, v_ones, 1);
		// A half-matched text is wiped when the next pattern closes.
		add_beat(CMD_PATTERN, 32'd0, 0);
		add_beat(CMD_PATTERN, 32'd1, 1);
		add_beat(CMD_TEXT, 32'd0, 0);
		add_beat(CMD_PATTERN, 32'd1, 1);
		add_beat(CMD_TEXT, 32'd1, 1);
		// Text end resets position and the reported flag for the next text.
		add_beat(CMD_TEXT, 32'd5, 1);
		add_beat(CMD_TEXT, 32'd2, 0);
		add_beat(CMD_TEXT, 32'd1, 1);

		// Back-to-back one-beat texts, each with a hit; the sink stalls here.
		fill = $urandom();
		add_beat(CMD_PATTERN, fill, 1);
		burst_at = beats_to_send.size();
		for (int i = 0; i < BURST_TEXTS; i++)
			add_beat(CMD_TEXT, fill, 1);

		rand_start = beats_to_send.size();
		texts_done = 0;
		while (beats_to_send.size() - rand_start < RANDOM_BEATS || texts_done < MIN_TEXTS) begin
			add_search_round($urandom_range(0, KIND_CUT), closed);
			texts_done += closed;
		end

		// Closing stretch runs with no idling on either side.
		calm_from = beats_to_send.size();
		for (int i = 0; i < CALM_ROUNDS; i++)
			add_search_round(KIND_CLEAN, closed);

		total_beats = beats_to_send.size();
	endtask

	// ------------------------------------------------------------------
	// Clock, reset and run control
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin : run_ctrl
		arst_n                = 1'b0;
		item_ch.valid         = 1'b0;
		item_ch.command       = CMD_PATTERN;
		item_ch.element_value = '0;
		item_ch.last_element  = 1'b0;
		result_ch.ready       = 1'b0;
		build_stimulus();
		repeat (8) @(posedge clk);
		// Release away from the active edge so the first beat is clean.
		@(negedge clk);
		arst_n <= 1'b1;
		while (items_in < total_beats) @(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		// Give any stray late result time to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	// Once the one-beat text burst starts, starve the result side so the
	// block's output fills and it has to back-pressure the item channel.
	initial begin : sink_starve
		while (!arst_n || items_in < burst_at) @(posedge clk);
		sink_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold = 1'b0;
	end

	// ------------------------------------------------------------------
	// Driver: present the next beat once the current one has been taken,
	// with random idle bursts until the closing stretch.
	// ------------------------------------------------------------------

	always @(negedge clk) begin : item_driver
		beat_t b;
		bit    offer;
		// Hold a beat that is still waiting for ready.
		if (arst_n && !(item_ch.valid && items_in != items_offered)) begin
			offer = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (beats_to_send.size() > 0) begin
				if (items_in < calm_from && $urandom_range(0, 11) == 0)
					send_gap = $urandom_range(0, 7);
				else
					offer = 1'b1;
			end
			if (offer) begin
				b = beats_to_send.pop_front();
				item_ch.command       <= b.command;
				item_ch.element_value <= b.value;
				item_ch.last_element  <= b.last;
				items_offered++;
			end
			item_ch.valid <= offer;
		end
	end

	// Result side: ready with random stall bursts, or held low while starved.
	always @(negedge clk) begin : result_sink
		bit take;
		if (arst_n) begin
			take = 1'b1;
			if (sink_hold) begin
				take = 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				take = 1'b0;
			end else if (items_in < calm_from && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 7);
				take = 1'b0;
			end
			result_ch.ready <= take;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check result beats first, then predict from the item beat.
	// ------------------------------------------------------------------

	always @(posedge clk) begin : monitor
		report_t want;
		beat_t   got_in;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_reports.size() == 0) begin
					$error("unexpected result beat: found=%0d start_position=%0d",
						result_ch.found, result_ch.start_position);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					if (result_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, result_ch.found);
						mismatches++;
					end
					if (result_ch.start_position !== want.start) begin
						$error("start_position: expected %0d, got %0d",
							want.start, result_ch.start_position);
						mismatches++;
					end
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				got_in.command = item_ch.command;
				got_in.value   = item_ch.element_value;
				got_in.last    = item_ch.last_element;
				predict_first_match(got_in);
				items_in <= items_in + 1;
			end
		end
	end

endmodule
